FILE: rtl/core/stack_allocator_with_padding_header_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stack allocator core
// Concurrent checks that are switched off as a whole by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef STACK_ALLOCATOR_WITH_PADDING_HEADER_CORE_MACROS_SVH
`define STACK_ALLOCATOR_WITH_PADDING_HEADER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clock and quiet during reset.
`define SAPAD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
// Next-cycle implication, sampled on clock and quiet during reset.
`define SAPAD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define SAPAD_ASSERT_SAME(label, ante, cons)
`define SAPAD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/sapad_pkg.sv
// ----------------------------------------------------------------------------
// Stack allocator package
// Field widths, status codes, action codes and register indexes.
// ----------------------------------------------------------------------------
package sapad_pkg;

   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned SIZE_W     = 24;
   localparam int unsigned PAD_W      = 8;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NO_SPACE    = 2'd1,
      STATUS_STACK_FULL  = 2'd2,
      STATUS_EMPTY_FREE  = 2'd3
   } status_type;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_SIZE   = 8'd1;

endpackage

FILE: rtl/core/sapad_if.sv
// ----------------------------------------------------------------------------
// Stack allocator channels
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface sapad_req_if;
   logic                              valid;
   logic                              ready;
   logic                              action;
   logic [sapad_pkg::SIZE_W-1:0]      request_size;
   logic [sapad_pkg::ADDR_W-1:0]      block_address;

   modport source (output valid, action, request_size, block_address, input ready);
   modport sink   (input valid, action, request_size, block_address, output ready);
endinterface

interface sapad_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sapad_pkg::ADDR_W-1:0]      result_address;
   sapad_pkg::status_type             status;
   logic [sapad_pkg::SIZE_W-1:0]      used_bytes;
   logic [sapad_pkg::SIZE_W-1:0]      peak_bytes;

   modport source (output valid, result_address, status, used_bytes, peak_bytes,
                   input ready);
   modport sink   (input valid, result_address, status, used_bytes, peak_bytes,
                   output ready);
endinterface

interface sapad_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sapad_pkg::CSR_IDX_W-1:0]   index;
   logic [sapad_pkg::CSR_DATA_W-1:0]  write_data;

   modport source (output valid, index, write_data, input ready);
   modport sink   (input valid, index, write_data, output ready);
endinterface

FILE: rtl/core/sapad_pad_stack.sv
// ----------------------------------------------------------------------------
// Padding stack memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sapad_pad_stack #(
   parameter int unsigned  DEPTH = 16,
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             wr_addr,
   input  logic [sapad_pkg::PAD_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [IDX_W-1:0]             rd_addr,
   output logic [sapad_pkg::PAD_W-1:0]  rd_data
);

   logic [sapad_pkg::PAD_W-1:0] mem_ff [DEPTH];
   logic [sapad_pkg::PAD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/stack_allocator_with_padding_header_core.sv
// ----------------------------------------------------------------------------
// Stack allocator with padding header
// LIFO bump allocator with 8-byte alignment and an on-chip padding stack.
// ----------------------------------------------------------------------------
// Requests arrive on req_port: an allocate carries a size, a free carries the
// address of the most recent block. Every request yields exactly one response
// on rsp_port with the handed-out address, a status code, the bytes in use and
// the peak since reset. Region base and size are written on csr_port, which
// is always ready and must only be used while no request is in flight.
// A request is transferred in the idle state, which also reads the top of
// the padding stack memory; the execute state then uses the registered read
// data, updates offset, peak and stack count and writes the stack memory.
// No new request is taken until the previous one has left the execute
// state, since the padding stack read data is registered. The response
// register decouples the sides: a new request is taken while an earlier
// response still waits; if the receiver stalls, the execute state waits
// until that response has been transferred. A synchronous reset clears state,
// region, offset, peak, stack count and response valid; the padding stack contents need no clearing.
// ----------------------------------------------------------------------------
`include "stack_allocator_with_padding_header_core_macros.svh"

module stack_allocator_with_padding_header_core #(
   parameter int unsigned HEADER_BYTES = 8,
   parameter int unsigned STACK_DEPTH  = 16
) (
   input logic          clock,
   input logic          reset,
   sapad_req_if.sink    req_port,
   sapad_rsp_if.source  rsp_port,
   sapad_csr_if.sink    csr_port
);

   localparam int unsigned ADDR_W = sapad_pkg::ADDR_W;
   localparam int unsigned SIZE_W = sapad_pkg::SIZE_W;
   localparam int unsigned PAD_W  = sapad_pkg::PAD_W;
   localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int unsigned IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned END_W  = SIZE_W + 2;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);
   localparam logic [PAD_W-1:0] HDR_PAD   = PAD_W'(HEADER_BYTES);

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_EXEC = 2'b10
   } fsm_type;

   fsm_type                state_ff, state_in;
   logic [ADDR_W-1:0]      base_ff, base_in;
   logic [SIZE_W-1:0]      total_ff, total_in;
   logic [SIZE_W-1:0]      offset_ff, offset_in;
   logic [SIZE_W-1:0]      peak_ff, peak_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic                   act_ff;
   logic [SIZE_W-1:0]      size_ff;
   logic [ADDR_W-1:0]      blk_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   sapad_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic                   req_xfer;
   logic                   exec_go;
   logic [2:0]             low_bits;
   logic [PAD_W-1:0]       pad_first;
   logic [PAD_W-1:0]       pad_need;
   logic [PAD_W-1:0]       pad;
   logic [ADDR_W-1:0]      cur_addr;
   logic [ADDR_W-1:0]      alloc_addr;
   logic [END_W-1:0]       end_offset;
   logic                   no_space;
   logic                   stack_full;
   logic                   alloc_ok;
   logic [CNT_W-1:0]       count_dec;
   logic [SIZE_W-1:0]      free_offset;
   logic                   mem_wr_en;
   logic [PAD_W-1:0]       top_pad;

   assign req_port.ready = (state_ff == FSM_IDLE);
   assign req_xfer       = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;
   assign exec_go        = (state_ff == FSM_EXEC) && (!rsp_valid_ff || rsp_port.ready);

   // Padding to the next multiple of 8, widened in whole 8-byte steps until
   // the header fits. Only the low three address bits matter.
   always_comb begin
      low_bits  = base_ff[2:0] + offset_ff[2:0];
      pad_first = PAD_W'(8) - {{(PAD_W-3){1'b0}}, low_bits};
      pad_need  = HDR_PAD - pad_first;
      if (pad_first < HDR_PAD) begin
         pad = pad_first + ((pad_need + PAD_W'(7)) & ~PAD_W'(7));
      end else begin
         pad = pad_first;
      end
   end

   assign cur_addr   = base_ff + {{(ADDR_W-SIZE_W){1'b0}}, offset_ff};
   assign alloc_addr = cur_addr + {{(ADDR_W-PAD_W){1'b0}}, pad};
   assign end_offset = {2'b00, offset_ff} + {{(END_W-PAD_W){1'b0}}, pad}
                       + {2'b00, size_ff};
   assign no_space   = end_offset > {2'b00, total_ff};
   assign stack_full = (count_ff >= DEPTH_CNT);
   assign alloc_ok   = (act_ff == sapad_pkg::ACT_ALLOC) && !no_space && !stack_full;
   assign count_dec  = count_ff - CNT_W'(1);
   assign free_offset = blk_ff[SIZE_W-1:0]
                        - {{(SIZE_W-PAD_W){1'b0}}, top_pad}
                        - base_ff[SIZE_W-1:0];
   assign mem_wr_en  = exec_go && alloc_ok;

   sapad_pad_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_pad_stack (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (pad),
      .rd_en   (req_xfer),
      .rd_addr (count_dec[IDX_W-1:0]),
      .rd_data (top_pad)
   );

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      total_in      = total_ff;
      offset_in     = offset_ff;
      peak_in       = peak_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_port.valid) begin
         if (csr_port.index == sapad_pkg::CSR_BASE_ADDRESS) begin
            base_in = csr_port.write_data;
         end else if (csr_port.index == sapad_pkg::CSR_TOTAL_SIZE) begin
            total_in = csr_port.write_data[SIZE_W-1:0];
         end
      end

      if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         FSM_IDLE: begin
            if (req_xfer) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (exec_go) begin
               state_in      = FSM_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = sapad_pkg::STATUS_OK;
               if (act_ff == sapad_pkg::ACT_ALLOC) begin
                  // Out of space takes priority over a full stack.
                  priority if (no_space) begin
                     rsp_status_in = sapad_pkg::STATUS_NO_SPACE;
                  end else if (stack_full) begin
                     rsp_status_in = sapad_pkg::STATUS_STACK_FULL;
                  end else begin
                     rsp_addr_in = alloc_addr;
                     offset_in   = end_offset[SIZE_W-1:0];
                     count_in    = count_ff + CNT_W'(1);
                     if (end_offset[SIZE_W-1:0] > peak_ff) begin
                        peak_in = end_offset[SIZE_W-1:0];
                     end
                  end
               end else if (count_ff == '0) begin
                  rsp_status_in = sapad_pkg::STATUS_EMPTY_FREE;
               end else begin
                  count_in  = count_dec;
                  offset_in = free_offset;
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         base_ff      <= '0;
         total_ff     <= '0;
         offset_ff    <= '0;
         peak_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         total_ff     <= total_in;
         offset_ff    <= offset_in;
         peak_ff      <= peak_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         act_ff  <= req_port.action;
         size_ff <= req_port.request_size;
         blk_ff  <= req_port.block_address;
      end
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.result_address = rsp_addr_ff;
   assign rsp_port.status         = rsp_status_ff;
   assign rsp_port.used_bytes     = offset_ff;
   assign rsp_port.peak_bytes     = peak_ff;

   `SAPAD_ASSERT_SAME(a_count_bounded, 1'b1, count_ff <= DEPTH_CNT)
   `SAPAD_ASSERT_NEXT(a_xfer_to_exec, req_xfer, state_ff == FSM_EXEC && rsp_valid_ff == $past(rsp_valid_ff && !rsp_port.ready))
   `SAPAD_ASSERT_NEXT(a_alloc_pushes, mem_wr_en, count_ff == $past(count_ff) + CNT_W'(1))
   `SAPAD_ASSERT_NEXT(a_exec_responds, exec_go, rsp_valid_ff && state_ff == FSM_IDLE)

endmodule

FILE: test/sapad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack allocator checker
// Watches the request, response and register channels, keeps its own copy of
// the allocator state and compares every response with the predicted one.
// ----------------------------------------------------------------------------
module sapad_checker #(
   parameter int unsigned HEADER_BYTES = 8,
   parameter int unsigned STACK_DEPTH  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   sapad_req_if                          req_mon,
   sapad_rsp_if                          rsp_mon,
   sapad_csr_if                          csr_mon,
   output int unsigned                   mismatch_count,
   output int unsigned                   replies_due,
   output logic [sapad_pkg::ADDR_W-1:0]  newest_block,
   output int unsigned                   blocks_held
);
   import sapad_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      status_type        status;
      logic [SIZE_W-1:0] used;
      logic [SIZE_W-1:0] peak;
   } alloc_reply_type;

   logic [ADDR_W-1:0] region_base;
   logic [SIZE_W-1:0] region_size;
   logic [SIZE_W-1:0] offset_now;
   logic [SIZE_W-1:0] offset_peak;
   logic [PAD_W-1:0]  pad_stack [STACK_DEPTH];
   logic [ADDR_W-1:0] block_stack [STACK_DEPTH];
   int unsigned       depth;
   alloc_reply_type   due_replies [$];

   // Distance from addr to the next multiple of 8, widened in whole 8-byte
   // steps until the header fits.
   function automatic logic [PAD_W-1:0] header_padding(input logic [ADDR_W-1:0] addr);
      int unsigned gap;
      int unsigned short_by;
      gap = 8 - addr[2:0];
      if (gap < HEADER_BYTES) begin
         short_by = HEADER_BYTES - gap;
         gap += 8 * ((short_by + 7) / 8);
      end
      return gap[PAD_W-1:0];
   endfunction

   task automatic apply_request(input logic act, input logic [SIZE_W-1:0] size,
                                input logic [ADDR_W-1:0] blk);
      logic [ADDR_W-1:0] cursor;
      logic [ADDR_W-1:0] rewind;
      logic [PAD_W-1:0]  pad;
      logic [SIZE_W+1:0] fill_end;
      alloc_reply_type   reply;
      reply = '0;
      reply.status = STATUS_OK;
      if (act == ACT_ALLOC) begin
         cursor   = region_base + offset_now;
         pad      = header_padding(cursor);
         // The space check is done at full width, without wrapping.
         fill_end = {2'b00, offset_now} + {{(SIZE_W-PAD_W+2){1'b0}}, pad}
                  + {2'b00, size};
         if (fill_end > {2'b00, region_size}) begin
            reply.status = STATUS_NO_SPACE;
         end else if (depth >= STACK_DEPTH) begin
            reply.status = STATUS_STACK_FULL;
         end else begin
            pad_stack[depth]   = pad;
            block_stack[depth] = cursor + pad;
            depth++;
            reply.address = cursor + pad;
            offset_now    = fill_end[SIZE_W-1:0];
            if (offset_now > offset_peak) begin
               offset_peak = offset_now;
            end
         end
      end else if (depth == 0) begin
         reply.status = STATUS_EMPTY_FREE;
      end else begin
         depth--;
         rewind     = blk - pad_stack[depth] - region_base;
         offset_now = rewind[SIZE_W-1:0];
      end
      reply.used = offset_now;
      reply.peak = offset_peak;
      due_replies.push_back(reply);
   endtask

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      alloc_reply_type want;
      if (reset) begin
         region_base    = '0;
         region_size    = '0;
         offset_now     = '0;
         offset_peak    = '0;
         depth          = 0;
         mismatch_count = 0;
         due_replies.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_BASE_ADDRESS: region_base = csr_mon.write_data[ADDR_W-1:0];
               CSR_TOTAL_SIZE:   region_size = csr_mon.write_data[SIZE_W-1:0];
               default: ;
            endcase
         end
         // A request is predicted before a response of the same edge is
         // compared, so a pass-through block would still line up.
         if (req_mon.valid && req_mon.ready) begin
            apply_request(req_mon.action, req_mon.request_size, req_mon.block_address);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_replies.size() == 0) begin
               $error("response transfer with no request outstanding: address 0x%0h",
                      rsp_mon.result_address);
               mismatch_count++;
            end else begin
               want = due_replies.pop_front();
               check_field("result_address", 32'(want.address),
                           32'(rsp_mon.result_address));
               check_field("status", 32'(want.status), 32'(rsp_mon.status));
               check_field("used_bytes", 32'(want.used), 32'(rsp_mon.used_bytes));
               check_field("peak_bytes", 32'(want.peak), 32'(rsp_mon.peak_bytes));
            end
         end
      end
      replies_due  = due_replies.size();
      blocks_held  = depth;
      newest_block = (depth != 0) ? block_stack[depth-1] : '0;
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack allocator testbench
// Drives allocate and free requests through directed corner cases and random
// phases with varying region settings, idling and back-pressure; a checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import sapad_pkg::*;

   localparam int unsigned HEADER_BYTES = 8;
   localparam int unsigned STACK_DEPTH  = 16;
   // The slowest run has about two thousand requests plus the long receiver
   // hold-off; this limit covers it many times over.
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned HOLD_CYCLES  = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int unsigned       mismatch_count;
   int unsigned       replies_due;
   int unsigned       blocks_held;
   logic [ADDR_W-1:0] newest_block;

   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;
   int unsigned cycle_count;
   int unsigned hold_left = 0;
   bit          hold_asked = 1'b0;

   sapad_req_if req_ch ();
   sapad_rsp_if rsp_ch ();
   sapad_csr_if csr_ch ();

   stack_allocator_with_padding_header_core #(
      .HEADER_BYTES (HEADER_BYTES),
      .STACK_DEPTH  (STACK_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   sapad_checker #(
      .HEADER_BYTES (HEADER_BYTES),
      .STACK_DEPTH  (STACK_DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_mon        (csr_ch),
      .mismatch_count (mismatch_count),
      .replies_due    (replies_due),
      .newest_block   (newest_block),
      .blocks_held    (blocks_held)
   );

   always #2 clock = ~clock;

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Receiver: random stalls, or one long hold-off when the stimulus asks.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_asked) begin
            hold_asked = 1'b0;
            hold_left  = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // All tasks start and end at a falling edge. The request valid is left
   // high after a transfer so that back-to-back requests need no gap.
   task automatic send(input logic act, input logic [SIZE_W-1:0] size,
                       input logic [ADDR_W-1:0] blk);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.action        <= act;
      req_ch.request_size  <= size;
      req_ch.block_address <= blk;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      while (replies_due != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid      <= 1'b1;
      csr_ch.index      <= idx;
      csr_ch.write_data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
   endtask

   // Frees every outstanding block at its own address, so the offset rewinds
   // cleanly before the base moves, then reprograms the region while idle.
   task automatic set_phase(input logic [ADDR_W-1:0] base, input logic [31:0] size_word,
                            input int unsigned send_gap, input int unsigned recv_gap);
      while (blocks_held != 0) send(ACT_FREE, SIZE_W'($urandom()), newest_block);
      wait_quiet();
      write_register(CSR_BASE_ADDRESS, base);
      write_register(CSR_TOTAL_SIZE, size_word);
      csr_ch.valid <= 1'b0;
      idle_pct  = send_gap;
      stall_pct = recv_gap;
   endtask

   task automatic random_item();
      int unsigned       pick;
      int unsigned       size_pick;
      logic [31:0]       size_word;
      logic [SIZE_W-1:0] size;
      pick      = $urandom_range(0, 99);
      size_pick = $urandom_range(0, 99);
      if (size_pick < 70) begin
         size_word = $urandom_range(0, 48);
      end else if (size_pick < 95) begin
         size_word = $urandom_range(0, 4095);
      end else begin
         size_word = $urandom();
      end
      size = size_word[SIZE_W-1:0];
      if (blocks_held == 0) begin
         if (pick < 90) begin
            send(ACT_ALLOC, size, $urandom());
         end else begin
            send(ACT_FREE, size, $urandom());
         end
      end else if (pick < 52) begin
         send(ACT_ALLOC, size, $urandom());
      end else if (pick < 90 || blocks_held < 2) begin
         send(ACT_FREE, size, newest_block);
      end else if (pick < 95) begin
         // A free near the newest block, up to 32 bytes either side of it.
         send(ACT_FREE, size, newest_block + $urandom_range(0, 64) - 32);
      end else begin
         // Never popping the last block here keeps the offset recoverable.
         send(ACT_FREE, size, $urandom());
      end
   endtask

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.action        = ACT_ALLOC;
      req_ch.request_size  = '0;
      req_ch.block_address = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = CSR_BASE_ADDRESS;
      csr_ch.write_data    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Region of size zero straight after reset, and a free of an empty stack.
      send(ACT_ALLOC, '0, 32'hFFFF_FFFF);
      send(ACT_FREE, 24'hFF_FFFF, 32'hFFFF_FFFF);
      send(ACT_ALLOC, 24'hFF_FFFF, 32'h0000_0000);

      // Base just below the top of the address space: the first block wraps.
      set_phase(32'hFFFF_FFF3, 32'h00FF_FFFF, 0, 0);
      send(ACT_ALLOC, '0, $urandom());
      repeat (STACK_DEPTH - 1) send(ACT_ALLOC, SIZE_W'($urandom_range(1, 40)), $urandom());
      send(ACT_ALLOC, 24'd1, $urandom());
      // Full stack and no space at once: the space check wins.
      send(ACT_ALLOC, 24'hFF_FFFF, $urandom());
      send(ACT_FREE, SIZE_W'($urandom()), newest_block - 32'h100);
      send(ACT_FREE, SIZE_W'($urandom()), newest_block + 32'd24);
      send(ACT_FREE, SIZE_W'($urandom()), newest_block);

      repeat (200) random_item();

      set_phase(32'h0000_0000, 32'h0000_0000, 63, 0);
      repeat (60) random_item();

      set_phase($urandom(), 32'h0000_0140, 0, 63);
      repeat (220) random_item();

      // Upper bits of the size word lie outside the register.
      set_phase(32'hFFFF_FFFF, 32'hFF00_0400, 17, 17);
      repeat (220) random_item();

      // The receiver holds off while requests keep coming, then the sender
      // waits for every response before going on.
      set_phase(32'h0000_0005, 32'h0000_0FFF, 0, 0);
      repeat (60) random_item();
      hold_asked = 1'b1;
      repeat (80) random_item();
      wait_quiet();
      repeat (80) random_item();

      set_phase($urandom(), 32'h00FF_FFFF, 63, 0);
      repeat (200) random_item();

      set_phase(32'h8000_0000, 32'h0000_0258, 0, 63);
      repeat (220) random_item();

      set_phase($urandom(), $urandom_range(64, 5000), 17, 17);
      repeat (180) random_item();

      wait_quiet();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
